// ===== sv/blcu_pkg.sv =====
// package for the bit-plane life cell update unit
// holds sizes, register indexes, control word types and the microcode table
// no dependencies
`default_nettype none

package blcu_pkg;

	localparam int MAX_ROWS      = 128;
	localparam int MAX_COLS      = 128;
	localparam int ROW_W         = $clog2(MAX_ROWS);
	localparam int COL_W         = $clog2(MAX_COLS);
	localparam int ADDR_W        = ROW_W + COL_W;
	localparam int DEPTH         = MAX_ROWS * MAX_COLS;
	localparam int CHAN_W        = 8;
	localparam int PLANES        = 3 * CHAN_W;
	localparam int CNT_W         = 4;
	localparam int MASK_W        = 18;
	localparam int SURVIVE_SHIFT = 9;
	localparam int SIZE_W        = 8;
	localparam int CFG_W         = 18;
	localparam int CFG_ADDR_W    = 2;
	localparam int STEP_W        = 4;
	localparam int IN_DATA_W     = 40;
	localparam int OUT_DATA_W    = 24;

	localparam logic [MASK_W-1:0] RULE_RESET = 18'h01808;

	// register indexes of the configuration port
	localparam logic [CFG_ADDR_W-1:0] CFG_RULE   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd2;

	// request kinds carried on tuser
	localparam logic ACT_STORE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef logic [STEP_W-1:0] step_t;

	// neighbour offset along one axis
	typedef enum logic [1:0] {
		OFF_MINUS,
		OFF_ZERO,
		OFF_PLUS
	} off_t;

	// how the step counter moves after this step
	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_QUERY,
		SEQ_WAIT_OUT
	} seq_op_t;

	typedef struct packed {
		logic    wait_in;
		logic    rd_en;
		off_t    dr;
		off_t    dc;
		logic    ld_self;
		logic    acc_nb;
		logic    decide;
		seq_op_t seq;
		step_t   target;
	} blcu_ctrl_t;

	typedef struct packed {
		logic query_go;
		logic out_free;
	} blcu_status_t;

	function automatic blcu_ctrl_t rd_word(off_t dr, off_t dc, logic ld, logic acc);
		blcu_ctrl_t w;
		w.wait_in = 1'b0;
		w.rd_en   = 1'b1;
		w.dr      = dr;
		w.dc      = dc;
		w.ld_self = ld;
		w.acc_nb  = acc;
		w.decide  = 1'b0;
		w.seq     = SEQ_NEXT;
		w.target  = '0;
		return w;
	endfunction

	// microcode: step 0 waits for a request, 1..9 read the 3x3 window,
	// step 10 folds in the last neighbour, applies the rule and returns
	function automatic blcu_ctrl_t ucode_rom(step_t step);
		blcu_ctrl_t w;
		w.wait_in = 1'b1;
		w.rd_en   = 1'b0;
		w.dr      = OFF_ZERO;
		w.dc      = OFF_ZERO;
		w.ld_self = 1'b0;
		w.acc_nb  = 1'b0;
		w.decide  = 1'b0;
		w.seq     = SEQ_WAIT_QUERY;
		w.target  = step_t'(1);
		case (step)
			4'd1:  w = rd_word(OFF_ZERO,  OFF_ZERO,  1'b0, 1'b0);
			4'd2:  w = rd_word(OFF_MINUS, OFF_MINUS, 1'b1, 1'b0);
			4'd3:  w = rd_word(OFF_MINUS, OFF_ZERO,  1'b0, 1'b1);
			4'd4:  w = rd_word(OFF_MINUS, OFF_PLUS,  1'b0, 1'b1);
			4'd5:  w = rd_word(OFF_ZERO,  OFF_MINUS, 1'b0, 1'b1);
			4'd6:  w = rd_word(OFF_ZERO,  OFF_PLUS,  1'b0, 1'b1);
			4'd7:  w = rd_word(OFF_PLUS,  OFF_MINUS, 1'b0, 1'b1);
			4'd8:  w = rd_word(OFF_PLUS,  OFF_ZERO,  1'b0, 1'b1);
			4'd9:  w = rd_word(OFF_PLUS,  OFF_PLUS,  1'b0, 1'b1);
			4'd10: begin
				w.wait_in = 1'b0;
				w.decide  = 1'b1;
				w.seq     = SEQ_WAIT_OUT;
				w.target  = '0;
			end
			default: ;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== sv/blcu_sequencer.sv =====
// step counter and microcode fetch for the life cell update unit
// depends on blcu_pkg for the control word, status struct and table
`default_nettype none

module blcu_sequencer
	import blcu_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire blcu_status_t status,
	output blcu_ctrl_t        ctrl
);

	step_t step_q;
	step_t step_d;

	assign ctrl = ucode_rom(step_q);

	always_comb begin
		case (ctrl.seq)
			SEQ_NEXT:       step_d = step_q + step_t'(1);
			SEQ_WAIT_QUERY: step_d = status.query_go ? ctrl.target : step_q;
			SEQ_WAIT_OUT:   step_d = status.out_free ? ctrl.target : step_q;
			default:        step_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bitplane_life_cell_update_unit.sv =====
// top level of the bit-plane life cell update unit: frame memory and datapath
// depends on blcu_pkg and blcu_sequencer
//
// usage
//   s_* carries requests: s_tuser is the kind (store pixel or query cell),
//   s_tdata holds row, column and the pixel. a store in range is written
//   into the frame memory in the cycle it is accepted and gives no result.
//   a request outside the configured height/width is dropped.
//   a query in range walks the 3x3 window through the one frame memory
//   read port (nine reads), counts live neighbours per bit plane and
//   applies the birth/survive rule; its result appears on m_*.
//   a store or dropped request leaves s_tready high for the next one,
//   while a query holds it low through the nine serial reads of the
//   single read port and the decide step of the microcode.
//   the result sits in an output register, so the next request is taken
//   while it waits; a query that finishes while the previous result is
//   still held stalls in its decide step until m_tready frees the register.
//   reset clears the sequencer, output valid and the registers to their
//   defaults (rule 0x1808, 128x128); the frame memory is not cleared and
//   must be written before it is queried. configuration must be written
//   only while no query is in flight; the unit does not enforce this.
`default_nettype none

module bitplane_life_cell_update_unit
	import blcu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request channel
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// cell_row[6:0], cell_col[13:7], red[21:14], green[29:22], blue[37:30]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// action[0]
	input  wire logic                  s_tuser,
	// result channel
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// next_red[7:0], next_green[15:8], next_blue[23:16]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]      cfg_wdata
);

	// request fields
	logic [ROW_W-1:0]    in_row;
	logic [COL_W-1:0]    in_col;
	logic [PLANES-1:0]   in_pix;
	logic                s_acc;
	logic                in_range;
	logic                mem_we;

	// configuration registers
	logic [MASK_W-1:0]   mask_q;
	logic [SIZE_W-1:0]   height_q;
	logic [SIZE_W-1:0]   width_q;
	logic [SIZE_W-1:0]   eff_h;
	logic [SIZE_W-1:0]   eff_w;
	logic [ROW_W-1:0]    last_row;
	logic [COL_W-1:0]    last_col;

	// sequencer interface
	blcu_ctrl_t          ctrl;
	blcu_status_t        status;

	// datapath
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    rd_row;
	logic [COL_W-1:0]    rd_col;
	logic [PLANES-1:0]   rdata_q;
	logic [PLANES-1:0]   self_q;
	logic [CNT_W-1:0]    cnt_q [PLANES];
	logic [PLANES-1:0]   next_pix;
	logic                out_free;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// frame memory, row-major, one write and one registered read port
	logic [PLANES-1:0]   mem_q [DEPTH];

	assign in_row = s_tdata[ROW_W-1:0];
	assign in_col = s_tdata[ROW_W+COL_W-1:ROW_W];
	// stored word keeps red in the top byte, blue in the bottom byte
	assign in_pix = {s_tdata[ADDR_W+CHAN_W-1:ADDR_W],
		s_tdata[ADDR_W+2*CHAN_W-1:ADDR_W+CHAN_W],
		s_tdata[ADDR_W+3*CHAN_W-1:ADDR_W+2*CHAN_W]};

	// sizes above the frame act as the frame size
	assign eff_h = (height_q > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : height_q;
	assign eff_w = (width_q > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : width_q;
	assign last_row = ROW_W'(eff_h - SIZE_W'(1));
	assign last_col = COL_W'(eff_w - SIZE_W'(1));

	assign in_range = (SIZE_W'(in_row) < eff_h) && (SIZE_W'(in_col) < eff_w);

	assign s_tready = ctrl.wait_in;
	assign s_acc    = s_tvalid && s_tready;
	assign mem_we   = s_acc && in_range && (s_tuser == ACT_STORE);
	assign out_free = !m_tvalid_q || m_tready;

	assign status.query_go = s_acc && in_range && (s_tuser == ACT_QUERY);
	assign status.out_free = out_free;

	blcu_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// configuration writes, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= RULE_RESET;
			height_q <= SIZE_W'(MAX_ROWS);
			width_q  <= SIZE_W'(MAX_COLS);
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_RULE:   mask_q   <= cfg_wdata[MASK_W-1:0];
				CFG_HEIGHT: height_q <= cfg_wdata[SIZE_W-1:0];
				CFG_WIDTH:  width_q  <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// toroidal wrap of the window coordinates, base cell always in range
	always_comb begin
		case (ctrl.dr)
			OFF_MINUS: rd_row = (row_q == '0) ? last_row : row_q - ROW_W'(1);
			OFF_PLUS:  rd_row = (row_q == last_row) ? '0 : row_q + ROW_W'(1);
			default:   rd_row = row_q;
		endcase
		case (ctrl.dc)
			OFF_MINUS: rd_col = (col_q == '0) ? last_col : col_q - COL_W'(1);
			OFF_PLUS:  rd_col = (col_q == last_col) ? '0 : col_q + COL_W'(1);
			default:   rd_col = col_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[{in_row, in_col}] <= in_pix;
		end
		if (ctrl.rd_en) begin
			rdata_q <= mem_q[{rd_row, rd_col}];
		end
	end

	// latch the cell, clear the counters, then accumulate one neighbour a step
	always_ff @(posedge clk) begin
		if (s_acc) begin
			row_q <= in_row;
			col_q <= in_col;
			for (int p = 0; p < PLANES; p++) begin
				cnt_q[p] <= '0;
			end
		end else if (ctrl.acc_nb) begin
			for (int p = 0; p < PLANES; p++) begin
				cnt_q[p] <= cnt_q[p] + CNT_W'(rdata_q[p]);
			end
		end
		if (ctrl.ld_self) begin
			self_q <= rdata_q;
		end
	end

	// rule lookup per plane, the last neighbour is still in the read register
	always_comb begin
		logic [CNT_W-1:0] cnt;
		logic [4:0]       idx;
		for (int p = 0; p < PLANES; p++) begin
			cnt = cnt_q[p] + CNT_W'(rdata_q[p]);
			idx = self_q[p] ? (5'(cnt) + 5'(SURVIVE_SHIFT)) : 5'(cnt);
			next_pix[p] = mask_q[idx];
		end
	end

	// output register, loaded by the decide step once it is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.decide && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.decide && out_free) begin
			m_tdata_q <= {next_pix[CHAN_W-1:0], next_pix[2*CHAN_W-1:CHAN_W],
				next_pix[3*CHAN_W-1:2*CHAN_W]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a query in range takes the channel off the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.query_go |=> !s_tready)
		else $error("request channel still open after query accept");

	// a decided result always lands in the output register
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.decide && out_free) |=> m_tvalid)
		else $error("decided result not presented");

	// the decide step never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("held result overwritten");

	// frame memory is not written while a query walks the window
	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd_en |-> !mem_we)
		else $error("frame write during window read");

	// the plane 0 neighbour counter holds at most seven at the decide step, before the last neighbour
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.decide |-> (cnt_q[0] <= CNT_W'(7)))
		else $error("neighbour count overflow");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking bench for bitplane_life_cell_update_unit: directed and random store/query
// traffic with a cycle-free color predictor and a scoreboard on the result stream
// depends on blcu_pkg and the unit's rtl
`timescale 1ns / 1ps

module tb_top
	import blcu_pkg::*;
();

	// timing knobs
	localparam int unsigned DRAIN_CYCLES   = 24;      // extra wait once requests and colors are drained
	localparam int unsigned BACKLOG_CYCLES = 300;     // long receiver hold-off, fills the unit
	localparam int unsigned FILL_LIMIT     = 150;     // grids up to this many cells are filled whole

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic [1:0]        pad;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} req_word_t;

	// m_tdata layout, next_red in the lowest byte
	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} color_word_t;

	typedef struct {
		logic      kind;
		req_word_t word;
	} cell_req_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request side
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = ACT_STORE;

	// result side
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// configuration port
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_RULE;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	// shadow of the unit's registers, changed only while the unit is idle
	logic [MASK_W-1:0] rule_mask = RULE_RESET;
	logic [SIZE_W-1:0] rows_cfg  = SIZE_W'(MAX_ROWS);
	logic [SIZE_W-1:0] cols_cfg  = SIZE_W'(MAX_COLS);

	// predictor state: frame contents as the unit should hold them
	logic [PLANES-1:0] frame_model [DEPTH];
	// stimulus side bookkeeping: cells that a store in range has reached
	bit                cell_written [DEPTH];

	cell_req_t   pending_reqs [$];
	color_word_t expected_colors [$];

	// driver state
	cell_req_t   next_req;
	int unsigned send_gap  = 0;
	bit          send_calm = 1'b0;

	// receiver state
	int unsigned ready_hold      = 0;
	bit          ready_calm      = 1'b0;
	int unsigned next_backlog_at = 60;

	// monitor state
	int unsigned results_seen = 0;
	int unsigned mismatches   = 0;
	int unsigned phase_items  = 0;
	color_word_t got_color;
	color_word_t want_color;

	bitplane_life_cell_update_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hard stop in case the unit hangs
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// sizes above the frame act as the frame size
	function automatic int unsigned eff_rows();
		return (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
	endfunction

	function automatic int unsigned eff_cols();
		return (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
	endfunction

	// next generation of all 24 planes of one cell, wrapping at h x w
	function automatic logic [PLANES-1:0] next_generation(int unsigned r, int unsigned c,
			int unsigned h, int unsigned w);
		logic [PLANES-1:0] nbr [8];
		logic [PLANES-1:0] self_px;
		logic [PLANES-1:0] nxt;
		int unsigned       n;
		int unsigned       cnt;
		n       = 0;
		nxt     = '0;
		self_px = frame_model[r * MAX_COLS + c];
		for (int unsigned dr = 0; dr < 3; dr++) begin
			for (int unsigned dc = 0; dc < 3; dc++) begin
				if (!(dr == 1 && dc == 1)) begin
					nbr[n] = frame_model[((r + h + dr - 1) % h) * MAX_COLS
						+ ((c + w + dc - 1) % w)];
					n++;
				end
			end
		end
		for (int unsigned p = 0; p < PLANES; p++) begin
			cnt = 0;
			for (int unsigned k = 0; k < 8; k++)
				cnt += nbr[k][p];
			// live cell looks up the survive half, dead cell the birth half
			nxt[p] = self_px[p] ? rule_mask[SURVIVE_SHIFT + cnt] : rule_mask[cnt];
		end
		return nxt;
	endfunction

	// apply one accepted request to the frame model and queue its color, if any
	task automatic predict_request(input logic kind, input logic [IN_DATA_W-1:0] data);
		req_word_t         wd;
		int unsigned       h;
		int unsigned       w;
		logic [PLANES-1:0] nxt;
		wd = req_word_t'(data);
		h  = eff_rows();
		w  = eff_cols();
		// outside the grid: dropped, no result
		if (wd.row >= h || wd.col >= w)
			return;
		if (kind == ACT_STORE) begin
			frame_model[wd.row * MAX_COLS + wd.col] = {wd.red, wd.green, wd.blue};
		end else begin
			nxt = next_generation(wd.row, wd.col, h, w);
			expected_colors.push_back('{blue: nxt[7:0], green: nxt[15:8], red: nxt[23:16]});
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// ------------------------------------------------------------------
	// driver: one request at a time from pending_reqs, random gaps after each
	// ------------------------------------------------------------------

	function automatic int unsigned sender_gap(bit calm);
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= ACT_STORE;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			// slot is free: either nothing was offered or the last request went in
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() != 0) begin
				next_req = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= next_req.word;
				s_tuser  <= next_req.kind;
				send_gap <= sender_gap(send_calm);
				// switch between back-to-back stretches and gappy stretches
				if ($urandom_range(0, 59) == 0)
					send_calm <= !send_calm;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stalls plus a long hold-off after 60 results, then every 200 results
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			m_tready   <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (results_seen >= next_backlog_at) begin
			// sender keeps offering, so the unit fills and stalls its input
			m_tready        <= 1'b0;
			ready_hold      <= BACKLOG_CYCLES;
			next_backlog_at <= next_backlog_at + 200;
		end else begin
			if (ready_calm || $urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready   <= 1'b0;
				ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
					: $urandom_range(0, 3);
			end
			if ($urandom_range(0, 199) == 0)
				ready_calm <= !ready_calm;
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on request accept, compare on result accept
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				got_color = color_word_t'(m_tdata);
				results_seen <= results_seen + 1;
				if (expected_colors.size() == 0) begin
					report_mismatch($sformatf("result %06h with no query waiting", m_tdata));
				end else begin
					want_color = expected_colors.pop_front();
					if (got_color.red !== want_color.red)
						report_mismatch($sformatf("next_red got %02h want %02h",
							got_color.red, want_color.red));
					if (got_color.green !== want_color.green)
						report_mismatch($sformatf("next_green got %02h want %02h",
							got_color.green, want_color.green));
					if (got_color.blue !== want_color.blue)
						report_mismatch($sformatf("next_blue got %02h want %02h",
							got_color.blue, want_color.blue));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// wait until every request went in and every color came out, then let the unit settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_colors.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [MASK_W-1:0] rule, input int unsigned h_set,
			input int unsigned w_set);
		write_reg(CFG_RULE, CFG_W'(rule));
		write_reg(CFG_HEIGHT, CFG_W'(h_set));
		write_reg(CFG_WIDTH, CFG_W'(w_set));
		rule_mask = rule;
		rows_cfg  = SIZE_W'(h_set);
		cols_cfg  = SIZE_W'(w_set);
	endtask

	// mix of dense, sparse, empty and full pixels so that neighbour counts spread out
	function automatic logic [PLANES-1:0] random_pixel();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return PLANES'($urandom & $urandom);
			3:       return PLANES'($urandom | $urandom);
			default: return PLANES'($urandom);
		endcase
	endfunction

	task automatic push_request(input logic kind, input int unsigned r, input int unsigned c,
			input logic [PLANES-1:0] px);
		cell_req_t req;
		req.kind       = kind;
		req.word.pad   = '0;
		req.word.row   = ROW_W'(r);
		req.word.col   = COL_W'(c);
		req.word.red   = px[23:16];
		req.word.green = px[15:8];
		req.word.blue  = px[7:0];
		pending_reqs.push_back(req);
		phase_items++;
	endtask

	task automatic add_store(input int unsigned r, input int unsigned c,
			input logic [PLANES-1:0] px);
		push_request(ACT_STORE, r, c, px);
		// a store outside the grid is dropped and writes nothing
		if (r < eff_rows() && c < eff_cols())
			cell_written[r * MAX_COLS + c] = 1'b1;
	endtask

	// a query in range first gets stores for any window cell not written yet
	task automatic add_query(input int unsigned r, input int unsigned c);
		int unsigned h;
		int unsigned w;
		int unsigned rr;
		int unsigned cc;
		h = eff_rows();
		w = eff_cols();
		if (r < h && c < w) begin
			for (int unsigned dr = 0; dr < 3; dr++) begin
				for (int unsigned dc = 0; dc < 3; dc++) begin
					rr = (r + h + dr - 1) % h;
					cc = (c + w + dc - 1) % w;
					if (!cell_written[rr * MAX_COLS + cc])
						add_store(rr, cc, random_pixel());
				end
			end
		end
		// pixel fields are don't-care on a query, still toggled
		push_request(ACT_QUERY, r, c, PLANES'($urandom));
	endtask

	task automatic random_items(input int unsigned target);
		int unsigned h;
		int unsigned w;
		int unsigned pick;
		h = eff_rows();
		w = eff_cols();
		while (phase_items < target) begin
			pick = $urandom_range(0, 99);
			if (h == 0 || w == 0 || pick >= 88)
				add_query($urandom_range(0, 127), $urandom_range(0, 127));
			else if (pick < 50)
				add_query($urandom_range(0, h - 1), $urandom_range(0, w - 1));
			else if (pick < 75)
				add_store($urandom_range(0, h - 1), $urandom_range(0, w - 1), random_pixel());
			else
				add_store($urandom_range(0, 127), $urandom_range(0, 127), random_pixel());
		end
	endtask

	// one setting of the registers: optional full fill, then two halves of random
	// traffic with a full drain in between
	task automatic random_phase(input logic [MASK_W-1:0] rule, input int unsigned h_set,
			input int unsigned w_set, input int unsigned budget);
		set_config(rule, h_set, w_set);
		phase_items = 0;
		if (eff_rows() * eff_cols() <= FILL_LIMIT) begin
			for (int unsigned r = 0; r < eff_rows(); r++)
				for (int unsigned c = 0; c < eff_cols(); c++)
					add_store(r, c, random_pixel());
		end
		random_items(budget / 2);
		wait_drained();
		random_items(budget);
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: 128x128 frame, rule birth 3 / survive 2,3
		// corner cells with extreme pixels, then queries that wrap both axes
		add_store(127, 127, 24'hFFFFFF);
		add_store(0, 127, 24'h000000);
		add_store(0, 0, 24'hA55A0F);
		add_query(0, 0);
		add_query(127, 127);
		wait_drained();

		// zero height: every request dropped
		set_config(RULE_RESET, 0, MAX_COLS);
		add_store(0, 0, 24'hFFFFFF);
		add_query(0, 0);
		wait_drained();

		// single row, width above the frame acts as the full width
		set_config(RULE_RESET, 1, 255);
		add_query(0, 5);
		add_query(1, 5);
		add_store(1, 127, 24'h00FF00);
		add_query(0, 127);
		wait_drained();

		// random part, small grids mostly, rule extremes included
		random_phase(18'($urandom), 1, 1, 40);
		random_phase(18'h3FFFF, 2, 3, 50);
		random_phase(18'h00000, 3, 2, 30);
		random_phase(18'($urandom), 5, 7, 70);
		random_phase(18'($urandom), 12, 12, 180);
		random_phase(18'($urandom), 6, 0, 12);
		random_phase(18'($urandom), 255, 128, 60);
		random_phase(18'($urandom), 9, 4, 70);
		random_phase(RULE_RESET, 10, 10, 120);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
